// ===== hdl/dtiam_pkg.sv =====
package dtiam_pkg;

	localparam int LAMBDA_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int FIELD_W     = 16;
	localparam int MEAS_W      = 20;
	localparam int ANISO_W     = 17;

	// eigenvalue sum
	localparam int S_W   = LAMBDA_BITS + 2;
	// squares of eigenvalues and of their differences
	localparam int PW    = 2 * LAMBDA_BITS;
	// sum of three squares
	localparam int DSW   = 2 * LAMBDA_BITS + 2;
	// quotient bits of every divider, also the radicand width of the roots
	localparam int QW    = 2 * FRAC_BITS + 2;
	// divisor width, holds s*s
	localparam int DW    = 2 * S_W;
	// dividend width
	localparam int NW    = QW + DW;
	// root width
	localparam int SQ_W  = FRAC_BITS + 1;

	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_FA_ENABLE = 3'd0;
	localparam logic [ADDR_W-1:0] REG_RA_ENABLE = 3'd4;

	typedef struct packed {
		logic neg_l;
		logic neg_p;
		logic order_err;
		logic zero;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] num_l;
		logic [NW-1:0] num_p;
		logic [NW-1:0] num_s;
		logic [NW-1:0] num_x;
		logic [DW-1:0] den_r;
		logic [DW-1:0] den_fa;
		logic [DW-1:0] den_ra;
		side_t         side;
	} front_t;

	typedef struct packed {
		logic fa_en;
		logic ra_en;
	} cfg_t;

endpackage

// ===== hdl/dtiam_in_if.sv =====
interface dtiam_in_if;
	import dtiam_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] lambda_largest;
	logic [FIELD_W-1:0] lambda_middle;
	logic [FIELD_W-1:0] lambda_smallest;

	modport source (output valid, lambda_largest, lambda_middle, lambda_smallest, input ready);
	modport sink (input valid, lambda_largest, lambda_middle, lambda_smallest, output ready);
endinterface

// ===== hdl/dtiam_out_if.sv =====
interface dtiam_out_if;
	import dtiam_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [MEAS_W-1:0] linear_measure;
	logic signed [MEAS_W-1:0] planar_measure;
	logic signed [MEAS_W-1:0] spherical_measure;
	logic [ANISO_W-1:0]       fractional_anisotropy;
	logic [ANISO_W-1:0]       relative_anisotropy;
	logic                     order_error;
	logic                     zero_sum;

	modport source (output valid, linear_measure, planar_measure, spherical_measure,
		fractional_anisotropy, relative_anisotropy, order_error, zero_sum, input ready);
	modport sink (input valid, linear_measure, planar_measure, spherical_measure,
		fractional_anisotropy, relative_anisotropy, order_error, zero_sum, output ready);
endinterface

// ===== hdl/dti_eigen_anisotropy_measures_core.sv =====
// channel    dir  beat payload
// vox_in     in   lambda_largest, lambda_middle, lambda_smallest (16b unsigned each)
// meas_out   out  linear/planar/spherical (20b signed), fa/ra (17b), order_error, zero_sum
// apb        in   fa_enable at 0x0, ra_enable at 0x4, bit 0
//
// one beat per cycle while meas_out does not stall; the path runs through the front stages,
// the one-bit-per-stage dividers, the one-bit-per-stage square roots and the output register
// reset clears the valid chain and sets both enables; no clearing pass
// a stall on meas_out freezes every stage at once, vox_in.ready follows it
module dti_eigen_anisotropy_measures_core (
	input  logic                         clk,
	input  logic                         arst_n,
	dtiam_in_if.sink                     vox_in,
	dtiam_out_if.source                  meas_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtiam_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import dtiam_pkg::*;

	localparam int LAT = 3 + QW + SQ_W + 1;
	localparam int SD  = QW + SQ_W;
	localparam int CW  = QW + MEAS_W;
	localparam int AW  = SQ_W + ANISO_W;

	cfg_t          cfg;
	front_t        fr;
	logic          adv;
	logic [LAT-1:0] vld_q;

	logic [QW-1:0]   q_l, q_p, q_s, q_fa, q_ra;
	logic [SQ_W-1:0] root_fa, root_ra;

	side_t         side_d [SD];
	logic [QW-1:0] ql_d [SQ_W];
	logic [QW-1:0] qp_d [SQ_W];
	logic [QW-1:0] qs_d [SQ_W];

	side_t side_o;

	function automatic logic [MEAS_W-1:0] fmt_ratio(input logic [QW-1:0] q, input logic neg);
		logic [CW-1:0]     qe;
		logic [CW-1:0]     lim;
		logic [MEAS_W-1:0] m;
		qe  = CW'(q);
		lim = neg ? (CW'(1) << (MEAS_W - 1)) : (CW'(1) << (MEAS_W - 1)) - CW'(1);
		if (qe > lim)
			qe = lim;
		m = qe[MEAS_W-1:0];
		return neg ? MEAS_W'(-m) : m;
	endfunction

	function automatic logic [ANISO_W-1:0] fmt_aniso(input logic [SQ_W-1:0] r);
		logic [AW-1:0] re;
		logic [AW-1:0] lim;
		re  = AW'(r);
		lim = (AW'(1) << ANISO_W) - AW'(1);
		if (re > lim)
			re = lim;
		return re[ANISO_W-1:0];
	endfunction

	dtiam_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv          = !vld_q[LAT-1] || meas_out.ready;
	assign vox_in.ready = adv;
	assign meas_out.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], vox_in.valid};
	end

	dtiam_front u_front (
		.clk             (clk),
		.adv             (adv),
		.lambda_largest  (vox_in.lambda_largest),
		.lambda_middle   (vox_in.lambda_middle),
		.lambda_smallest (vox_in.lambda_smallest),
		.fr              (fr)
	);

	dtiam_div u_div_l  (.clk(clk), .adv(adv), .num(fr.num_l), .den(fr.den_r),  .quo(q_l));
	dtiam_div u_div_p  (.clk(clk), .adv(adv), .num(fr.num_p), .den(fr.den_r),  .quo(q_p));
	dtiam_div u_div_s  (.clk(clk), .adv(adv), .num(fr.num_s), .den(fr.den_r),  .quo(q_s));
	dtiam_div u_div_fa (.clk(clk), .adv(adv), .num(fr.num_x), .den(fr.den_fa), .quo(q_fa));
	dtiam_div u_div_ra (.clk(clk), .adv(adv), .num(fr.num_x), .den(fr.den_ra), .quo(q_ra));

	dtiam_sqrt u_sqrt_fa (.clk(clk), .adv(adv), .rad(q_fa), .root(root_fa));
	dtiam_sqrt u_sqrt_ra (.clk(clk), .adv(adv), .rad(q_ra), .root(root_ra));

	// flags ride along the dividers and roots, ratios wait out the roots
	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= fr.side;
			for (int i = 1; i < SD; i++)
				side_d[i] <= side_d[i-1];
			ql_d[0] <= q_l;
			qp_d[0] <= q_p;
			qs_d[0] <= q_s;
			for (int i = 1; i < SQ_W; i++) begin
				ql_d[i] <= ql_d[i-1];
				qp_d[i] <= qp_d[i-1];
				qs_d[i] <= qs_d[i-1];
			end
		end
	end

	assign side_o = side_d[SD-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			meas_out.order_error <= side_o.order_err;
			meas_out.zero_sum    <= side_o.zero;
			if (side_o.zero) begin
				meas_out.linear_measure        <= '0;
				meas_out.planar_measure        <= '0;
				meas_out.spherical_measure     <= '0;
				meas_out.fractional_anisotropy <= '0;
				meas_out.relative_anisotropy   <= '0;
			end else begin
				meas_out.linear_measure    <= $signed(fmt_ratio(ql_d[SQ_W-1], side_o.neg_l));
				meas_out.planar_measure    <= $signed(fmt_ratio(qp_d[SQ_W-1], side_o.neg_p));
				meas_out.spherical_measure <= $signed(fmt_ratio(qs_d[SQ_W-1], 1'b0));
				meas_out.fractional_anisotropy <= cfg.fa_en ? fmt_aniso(root_fa) : '0;
				meas_out.relative_anisotropy   <= cfg.ra_en ? fmt_aniso(root_ra) : '0;
			end
		end
	end
endmodule

// ===== hdl/dtiam_cfg.sv =====
module dtiam_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtiam_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output dtiam_pkg::cfg_t              cfg
);
	import dtiam_pkg::*;

	logic fa_en_q;
	logic ra_en_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_en_q <= 1'b1;
			ra_en_q <= 1'b1;
		end else if (wr) begin
			case (paddr)
				REG_FA_ENABLE: fa_en_q <= pwdata[0];
				REG_RA_ENABLE: ra_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_FA_ENABLE: prdata = {31'd0, fa_en_q};
			REG_RA_ENABLE: prdata = {31'd0, ra_en_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg.fa_en = fa_en_q;
	assign cfg.ra_en = ra_en_q;
endmodule

// ===== hdl/dtiam_front.sv =====
module dtiam_front (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [dtiam_pkg::FIELD_W-1:0] lambda_largest,
	input  logic [dtiam_pkg::FIELD_W-1:0] lambda_middle,
	input  logic [dtiam_pkg::FIELD_W-1:0] lambda_smallest,
	output dtiam_pkg::front_t             fr
);
	import dtiam_pkg::*;

	logic [LAMBDA_BITS-1:0] a, b, c;
	logic [S_W-1:0]         s;

	logic [LAMBDA_BITS-1:0] a_s1, b_s1, c_s1, dab_s1, dbc_s1, dca_s1;
	logic [S_W-1:0]         s_s1;
	side_t                  side_s1;

	logic [PW-1:0]  sq_ab_s2, sq_bc_s2, sq_ca_s2, sq_a_s2, sq_b_s2, sq_c_s2;
	logic [DW-1:0]  s2_s2, den_r_s2;
	logic [NW-1:0]  num_l_s2, num_p_s2, num_s_s2;
	side_t          side_s2;

	logic [DSW-1:0] dsum;

	function automatic logic [LAMBDA_BITS-1:0] absdiff(input logic [LAMBDA_BITS-1:0] x,
		input logic [LAMBDA_BITS-1:0] y);
		return (x >= y) ? x - y : y - x;
	endfunction

	assign a = lambda_largest[LAMBDA_BITS-1:0];
	assign b = lambda_middle[LAMBDA_BITS-1:0];
	assign c = lambda_smallest[LAMBDA_BITS-1:0];
	assign s = S_W'(a) + S_W'(b) + S_W'(c);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= a;
			b_s1   <= b;
			c_s1   <= c;
			dab_s1 <= absdiff(a, b);
			dbc_s1 <= absdiff(b, c);
			dca_s1 <= absdiff(c, a);
			s_s1   <= s;
			side_s1.neg_l     <= a < b;
			side_s1.neg_p     <= b < c;
			side_s1.order_err <= !(a >= b && b >= c);
			side_s1.zero      <= s == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_ab_s2 <= PW'(dab_s1) * PW'(dab_s1);
			sq_bc_s2 <= PW'(dbc_s1) * PW'(dbc_s1);
			sq_ca_s2 <= PW'(dca_s1) * PW'(dca_s1);
			sq_a_s2  <= PW'(a_s1) * PW'(a_s1);
			sq_b_s2  <= PW'(b_s1) * PW'(b_s1);
			sq_c_s2  <= PW'(c_s1) * PW'(c_s1);
			s2_s2    <= DW'(s_s1) * DW'(s_s1);
			den_r_s2 <= DW'(s_s1);
			num_l_s2 <= NW'(S_W'(dab_s1)) << FRAC_BITS;
			num_p_s2 <= NW'(S_W'(dbc_s1) << 1) << FRAC_BITS;
			num_s_s2 <= NW'((S_W'(c_s1) << 1) + S_W'(c_s1)) << FRAC_BITS;
			side_s2  <= side_s1;
		end
	end

	assign dsum = DSW'(sq_ab_s2) + DSW'(sq_bc_s2) + DSW'(sq_ca_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			fr.num_l  <= num_l_s2;
			fr.num_p  <= num_p_s2;
			fr.num_s  <= num_s_s2;
			fr.num_x  <= NW'(dsum) << (2 * FRAC_BITS);
			fr.den_r  <= den_r_s2;
			fr.den_fa <= (DW'(sq_a_s2) + DW'(sq_b_s2) + DW'(sq_c_s2)) << 1;
			fr.den_ra <= s2_s2;
			fr.side   <= side_s2;
		end
	end
endmodule

// ===== hdl/dtiam_div.sv =====
module dtiam_div (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [dtiam_pkg::NW-1:0] num,
	input  logic [dtiam_pkg::DW-1:0] den,
	output logic [dtiam_pkg::QW-1:0] quo
);
	import dtiam_pkg::*;

	// one restoring step per stage; dividend bits leave the top of nq as quotient bits enter
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nq_s  [QW];
	logic [DW-1:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_in, den_in;
		logic [QW-1:0] nq_in;
		logic [DW:0]   t, diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = num[NW-1:QW];
			assign nq_in  = num[QW-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign t    = {rem_in, nq_in[QW-1]};
		assign diff = t - {1'b0, den_in};
		assign ge   = t >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
				nq_s[k]  <= {nq_in[QW-2:0], ge};
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = nq_s[QW-1];
endmodule

// ===== hdl/dtiam_sqrt.sv =====
module dtiam_sqrt (
	input  logic                       clk,
	input  logic                       adv,
	input  logic [dtiam_pkg::QW-1:0]   rad,
	output logic [dtiam_pkg::SQ_W-1:0] root
);
	import dtiam_pkg::*;

	localparam int RW = SQ_W + 2;

	// two radicand bits and one root bit per stage
	logic [RW-1:0]   rem_s  [SQ_W];
	logic [SQ_W-1:0] root_s [SQ_W];
	logic [QW-1:0]   rad_s  [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_step
		logic [RW-1:0]   rem_in;
		logic [SQ_W-1:0] root_in;
		logic [QW-1:0]   rad_in;
		logic [RW+1:0]   t, trial, diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		assign t     = {rem_in, rad_in[QW-1:QW-2]};
		assign trial = (RW+2)'({root_in, 2'b01});
		assign diff  = t - trial;
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? diff[RW-1:0] : t[RW-1:0];
				root_s[k] <= {root_in[SQ_W-2:0], ge};
				rad_s[k]  <= {rad_in[QW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQ_W-1];
endmodule
